@@ hw/rtl/slt_pkg.sv @@
// Package for the sorted list table: sizes, action and status codes, FSM states
// and the structs passed between the controller, the RAM port and the output stage.
// No dependencies.
package slt_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;
  localparam int ECNT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_READ_ASC  = 3'd1,
    ACT_READ_DESC = 3'd2,
    ACT_DELETE    = 3'd3,
    ACT_SEARCH    = 3'd4,
    ACT_GET_NTH   = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS_SCAN,
    S_INS_LAST,
    S_FIND,
    S_STREAM,
    S_GET,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    status_t           status;
    logic [ECNT_W-1:0] entry_count;
    logic              last;
  } res_t;

endpackage

@@ hw/rtl/sorted_list_table_top.sv @@
// Sorted list table: up to DEPTH signed 32-bit entries held in nondecreasing order.
// Requests arrive on in_ (in_action, in_operand) with valid/ready; results leave on
// out_ with valid/ready, one item per request except reads, which give one item
// per entry with out_last on the final one.
// Actions: insert, read ascending, read descending, delete first match, search,
// get the entry at a 1-based rank. Codes six and seven are dropped with no result.
// Reads give one item per cycle while out_ready stays high.
// Every step is one read of the entry RAM (registered read) plus at most one
// write-back.
// One request is worked at a time; in_ready rises once the last result is in the
// output register, so the next request is taken while that result waits.
// Reset empties the table (count zero); RAM contents are not cleared.
// A stalled receiver holds the output register; streaming reads pause with it.
module sorted_list_table_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [slt_pkg::ACT_W-1:0]  in_action,
  input  logic [slt_pkg::DATA_W-1:0] in_operand,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [slt_pkg::DATA_W-1:0] out_result_value,
  output logic [slt_pkg::STAT_W-1:0] out_status,
  output logic [slt_pkg::ECNT_W-1:0] out_entry_count,
  output logic                       out_last
);
  import slt_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] rd_data;
  logic              slot_free;
  res_t              res;

  slt_ram #(
    .W (DATA_W),
    .D (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  slt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_operand (in_operand),
    .ram_req    (ram_req),
    .rd_data    (rd_data),
    .slot_free  (slot_free),
    .res        (res)
  );

  slt_outreg u_outreg (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .slot_free        (slot_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_last         (out_last)
  );

  // shifting never writes the entry being fetched in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en && ram_req.rd_en |-> ram_req.wr_addr != ram_req.rd_addr)
    else $error("RAM read and write hit the same entry");

  // no table write while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !ram_req.wr_en)
    else $error("RAM written while idle");

  // a result is only produced while a request is being worked
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_ready)
    else $error("result produced while idle");

  // items before the last of a stream always carry ok
  a_stream_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK)
    else $error("non-final result item with error status");

endmodule

@@ hw/rtl/slt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while rd_en is low. No dependencies.
module slt_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] wr_addr,
  input  logic [W-1:0]                         wr_data,
  input  logic                                 rd_en,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] rd_addr,
  output logic [W-1:0]                         rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/slt_outreg.sv @@
// Result register between the controller and the out_ channel.
// Depends on slt_pkg (res_t).
module slt_outreg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  slt_pkg::res_t              res,
  output logic                       slot_free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [slt_pkg::DATA_W-1:0] out_result_value,
  output logic [slt_pkg::STAT_W-1:0] out_status,
  output logic [slt_pkg::ECNT_W-1:0] out_entry_count,
  output logic                       out_last
);
  import slt_pkg::*;

  logic              valid_r;
  logic [DATA_W-1:0] value_r;
  status_t           status_r;
  logic [ECNT_W-1:0] ecnt_r;
  logic              last_r;

  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= res.valid;
    end
    if (slot_free && res.valid) begin
      value_r  <= res.value;
      status_r <= res.status;
      ecnt_r   <= res.entry_count;
      last_r   <= res.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_value = value_r;
  assign out_status       = status_r;
  assign out_entry_count  = ecnt_r;
  assign out_last         = last_r;

endmodule

@@ hw/rtl/slt_ctrl.sv @@
// Controller of the sorted list table: sequences reads, compares and write-backs
// on the entry RAM for each request. Depends on slt_pkg.
module slt_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [slt_pkg::ACT_W-1:0]  in_action,
  input  logic [slt_pkg::DATA_W-1:0] in_operand,
  output slt_pkg::ram_req_t          ram_req,
  input  logic [slt_pkg::DATA_W-1:0] rd_data,
  input  logic                       slot_free,
  output slt_pkg::res_t              res
);
  import slt_pkg::*;

  state_t            state_r, state_nxt;
  logic [ACT_W-1:0]  act_r;
  logic [DATA_W-1:0] val_r;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic              found_r, found_nxt;
  logic              dv_r, dv_nxt;
  status_t           st_r, st_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;

  logic              cnt_full, cnt_zero, idx_at_end, rank_bad;
  logic [CW-1:0]     cnt_m1;
  logic              greater, match, is_read, is_find;
  logic              strm_load, strm_issue, strm_last;
  logic [AW-1:0]     strm_addr;

  assign in_ready   = (state_r == S_IDLE);
  assign cnt_full   = (cnt_r == CW'(DEPTH));
  assign cnt_zero   = (cnt_r == '0);
  assign cnt_m1     = cnt_r - CW'(1);
  assign idx_at_end = (CW'(idx_r) == cnt_m1);
  assign rank_bad   = (val_r == '0) || val_r[DATA_W-1] || (val_r > DATA_W'(cnt_r));
  assign greater    = $signed(rd_data) > $signed(val_r);
  assign match      = (rd_data == val_r);
  assign is_read    = (act_r == ACT_READ_ASC) || (act_r == ACT_READ_DESC);
  assign is_find    = (act_r == ACT_DELETE) || (act_r == ACT_SEARCH);

  // Streaming: RAM output holds the entry issued last; it moves on once loaded.
  assign strm_load  = dv_r && slot_free;
  assign strm_issue = (n_r != cnt_r) && (!dv_r || strm_load);
  assign strm_last  = (n_r == cnt_r);
  assign strm_addr  = (act_r == ACT_READ_ASC) ? n_r[AW-1:0] : AW'(cnt_m1 - n_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        priority if (act_r == ACT_INSERT) begin
          state_nxt = (cnt_full || cnt_zero) ? S_DONE : S_INS_SCAN;
        end else if (is_read) begin
          state_nxt = cnt_zero ? S_DONE : S_STREAM;
        end else if (is_find) begin
          state_nxt = cnt_zero ? S_DONE : S_FIND;
        end else if (act_r == ACT_GET_NTH) begin
          state_nxt = rank_bad ? S_DONE : S_GET;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INS_SCAN: begin
        if (!greater) state_nxt = S_DONE;
        else if (idx_r == '0) state_nxt = S_INS_LAST;
      end
      S_INS_LAST: state_nxt = S_DONE;
      S_FIND: begin
        if ((act_r == ACT_SEARCH && match) || idx_at_end) state_nxt = S_DONE;
      end
      S_STREAM: begin
        if (strm_load && strm_last) state_nxt = S_IDLE;
      end
      S_GET: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    found_nxt = found_r;
    dv_nxt    = dv_r;
    st_nxt    = st_r;
    value_nxt = value_r;
    ram_req   = '0;
    res       = '0;
    res.entry_count = ECNT_W'(cnt_r);
    res.status      = st_r;

    unique case (state_r)
      S_IDLE: ;
      S_START: begin
        value_nxt = '0;
        st_nxt    = ST_OK;
        priority if (act_r == ACT_INSERT) begin
          priority if (cnt_full) begin
            st_nxt = ST_FULL;
          end else if (cnt_zero) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = '0;
            ram_req.wr_data = val_r;
            cnt_nxt         = cnt_r + CW'(1);
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = AW'(cnt_m1);
            idx_nxt         = AW'(cnt_m1);
          end
        end else if (is_read) begin
          if (cnt_zero) st_nxt = ST_EMPTY;
          n_nxt  = '0;
          dv_nxt = 1'b0;
        end else if (is_find) begin
          if (cnt_zero) st_nxt = ST_NOTFOUND;
          ram_req.rd_en   = !cnt_zero;
          ram_req.rd_addr = '0;
          idx_nxt         = '0;
          found_nxt       = 1'b0;
        end else if (act_r == ACT_GET_NTH) begin
          if (rank_bad) st_nxt = ST_BADPOS;
          ram_req.rd_en   = !rank_bad;
          ram_req.rd_addr = AW'(val_r - DATA_W'(1));
        end else begin
          st_nxt = st_r;
        end
      end
      S_INS_SCAN: begin
        // walk down from the top, moving larger entries up one place
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = idx_r + AW'(1);
        if (greater) begin
          ram_req.wr_data = rd_data;
          if (idx_r != '0) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx_r - AW'(1);
            idx_nxt         = idx_r - AW'(1);
          end
        end else begin
          ram_req.wr_data = val_r;
          cnt_nxt         = cnt_r + CW'(1);
        end
      end
      S_INS_LAST: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = '0;
        ram_req.wr_data = val_r;
        cnt_nxt         = cnt_r + CW'(1);
      end
      S_FIND: begin
        found_nxt = found_r || match;
        // after the match, each later entry shifts down one place
        if (act_r == ACT_DELETE && found_r) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = idx_r - AW'(1);
          ram_req.wr_data = rd_data;
        end
        priority if (act_r == ACT_SEARCH && match) begin
          st_nxt = ST_OK;
        end else if (idx_at_end) begin
          if (found_r || match) begin
            st_nxt = ST_OK;
            if (act_r == ACT_DELETE) cnt_nxt = cnt_m1;
          end else begin
            st_nxt = ST_NOTFOUND;
          end
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = idx_r + AW'(1);
          idx_nxt         = idx_r + AW'(1);
        end
      end
      S_STREAM: begin
        res.valid  = strm_load;
        res.value  = rd_data;
        res.status = ST_OK;
        res.last   = strm_last;
        if (strm_issue) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = strm_addr;
          n_nxt           = n_r + CW'(1);
        end
        dv_nxt = strm_issue ? 1'b1 : (strm_load ? 1'b0 : dv_r);
      end
      S_GET: value_nxt = rd_data;
      S_DONE: begin
        res.valid = slot_free;
        res.value = value_r;
        res.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
    end
    if (in_valid && in_ready) begin
      act_r <= in_action;
      val_r <= in_operand;
    end
    idx_r   <= idx_nxt;
    n_r     <= n_nxt;
    found_r <= found_nxt;
    st_r    <= st_nxt;
    value_r <= value_nxt;
  end

endmodule

@@ tb/tb_sorted_list_table_top.sv @@
// Self-checking testbench for sorted_list_table_top: directed and random requests
// against a shadow copy of the sorted table, with random gaps and output stalls.
// Depends on slt_pkg and the sorted_list_table_top RTL only.
module tb_sorted_list_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import slt_pkg::*;

  localparam logic [ACT_W-1:0]  ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0]  ACT_SPARE_7 = 3'd7;
  localparam logic [DATA_W-1:0] INT_MIN     = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX     = 32'h7FFF_FFFF;

  typedef struct {
    logic [DATA_W-1:0] value;
    status_t           status;
    logic [ECNT_W-1:0] entry_count;
    logic              last;
  } table_result_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ACT_W-1:0]  in_action = ACT_INSERT;
  logic [DATA_W-1:0] in_operand = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic [DATA_W-1:0] out_result_value;
  logic [STAT_W-1:0] out_status;
  logic [ECNT_W-1:0] out_entry_count;
  logic              out_last;

  // shadow of the table contents and occupancy
  logic signed [DATA_W-1:0] shadow_tbl [DEPTH];
  int                       shadow_cnt = 0;
  table_result_t            pending_results [$];
  int                       mismatch_cnt = 0;
  bit                       no_idle = 1'b0;
  bit                       grow = 1'b1;

  sorted_list_table_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_operand       (in_operand),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void queue_result(logic [DATA_W-1:0] value, status_t status,
                                       logic last);
    table_result_t r;
    r.value       = value;
    r.status      = status;
    r.entry_count = shadow_cnt[ECNT_W-1:0];
    r.last        = last;
    pending_results.push_back(r);
  endfunction

  function automatic int find_entry(logic [DATA_W-1:0] value);
    for (int i = 0; i < shadow_cnt; i++)
      if (shadow_tbl[i] == value) return i;
    return -1;
  endfunction

  // Apply one accepted request to the shadow table and queue what it should produce.
  function automatic void predict_action(logic [ACT_W-1:0] act, logic [DATA_W-1:0] opnd);
    int pos;
    case (act)
      ACT_INSERT: begin
        if (shadow_cnt >= DEPTH) begin
          queue_result('0, ST_FULL, 1'b1);
        end else begin
          pos = 0;
          while (pos < shadow_cnt && shadow_tbl[pos] <= $signed(opnd)) pos++;
          for (int i = shadow_cnt; i > pos; i--) shadow_tbl[i] = shadow_tbl[i-1];
          shadow_tbl[pos] = opnd;
          shadow_cnt++;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      ACT_READ_ASC, ACT_READ_DESC: begin
        if (shadow_cnt == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_cnt; i++)
            queue_result(shadow_tbl[(act == ACT_READ_ASC) ? i : shadow_cnt - 1 - i],
                         ST_OK, i == shadow_cnt - 1);
        end
      end
      ACT_DELETE: begin
        pos = find_entry(opnd);
        if (pos < 0) begin
          queue_result('0, ST_NOTFOUND, 1'b1);
        end else begin
          for (int i = pos; i + 1 < shadow_cnt; i++) shadow_tbl[i] = shadow_tbl[i+1];
          shadow_cnt--;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      ACT_SEARCH: begin
        queue_result('0, (find_entry(opnd) < 0) ? ST_NOTFOUND : ST_OK, 1'b1);
      end
      ACT_GET_NTH: begin
        // rank is signed, so anything with the top bit set is below one
        if ($signed(opnd) < 1 || $signed(opnd) > shadow_cnt)
          queue_result('0, ST_BADPOS, 1'b1);
        else
          queue_result(shadow_tbl[opnd - 1], ST_OK, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [ACT_W-1:0] act, logic [DATA_W-1:0] opnd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_operand <= opnd;
    do @(posedge clk); while (!in_ready);
    predict_action(act, opnd);
  endtask

  task automatic check_result();
    table_result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("unexpected result: value %0d status %0d count %0d last %0b",
             $signed(out_result_value), out_status, out_entry_count, out_last);
      mismatch_cnt++;
      return;
    end
    exp_r = pending_results.pop_front();
    if (out_result_value !== exp_r.value) begin
      $error("result_value: expected %0d, got %0d", $signed(exp_r.value),
             $signed(out_result_value));
      mismatch_cnt++;
    end
    if (out_status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, out_status);
      mismatch_cnt++;
    end
    if (out_entry_count !== exp_r.entry_count) begin
      $error("entry_count: expected %0d, got %0d", exp_r.entry_count, out_entry_count);
      mismatch_cnt++;
    end
    if (out_last !== exp_r.last) begin
      $error("last: expected %0b, got %0b", exp_r.last, out_last);
      mismatch_cnt++;
    end
  endtask

  // result monitor and receiver stalls
  initial begin : result_side
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        check_result();
        stall = no_idle ? 0 : $urandom_range(0, 4);
        if (stall > 0) out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        if (stall == 0) out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return '1;
      3: return '0;
      4: return 32'd1;
      5: return 32'd7;
      6: return -32'sd100;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_rank();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    if (r == 1) return {1'b1, 31'($urandom())};
    return $urandom_range(0, shadow_cnt + 1);
  endfunction

  task automatic send_random();
    int               r;
    logic [ACT_W-1:0] act;
    logic [DATA_W-1:0] opnd;
    // swing between filling and draining so full and empty are both visited
    if (shadow_cnt >= DEPTH) grow = 1'b0;
    else if (shadow_cnt == 0) grow = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 2)       act = r[0] ? ACT_SPARE_7 : ACT_SPARE_6;
    else if (r < 37) act = grow ? ACT_INSERT : ACT_DELETE;
    else if (r < 47) act = grow ? ACT_DELETE : ACT_INSERT;
    else if (r < 57) act = ACT_READ_ASC;
    else if (r < 65) act = ACT_READ_DESC;
    else if (r < 80) act = ACT_SEARCH;
    else             act = ACT_GET_NTH;
    if (act == ACT_GET_NTH)
      opnd = pick_rank();
    else if ((act == ACT_DELETE || act == ACT_SEARCH) && shadow_cnt > 0 &&
             $urandom_range(0, 9) < 6)
      opnd = shadow_tbl[$urandom_range(0, shadow_cnt - 1)];
    else
      opnd = pick_value();
    send_request(act, opnd);
  endtask

  task automatic test_empty_table();
    send_request(ACT_READ_ASC, '0);
    send_request(ACT_SEARCH, 32'd3);
    send_request(ACT_DELETE, '0);
    send_request(ACT_GET_NTH, 32'd1);
    send_request(ACT_SPARE_6, INT_MAX);
  endtask

  task automatic test_fill_and_full();
    logic [DATA_W-1:0] fill [16];
    fill = '{INT_MIN, INT_MAX, '0, '1, 32'd1, '0, INT_MAX, INT_MIN,
             32'h5555_5555, 32'hAAAA_AAAA, 32'd100, -32'sd100, 32'd7, 32'd7,
             32'd42, -32'sd42};
    foreach (fill[i]) send_request(ACT_INSERT, fill[i]);
    send_request(ACT_INSERT, 32'd5);
    send_request(ACT_READ_ASC, '0);
    send_request(ACT_READ_DESC, '0);
    send_request(ACT_GET_NTH, 32'd16);
    send_request(ACT_GET_NTH, INT_MIN);
    send_request(ACT_SEARCH, INT_MAX);
    send_request(ACT_DELETE, INT_MIN);
    send_request(ACT_SPARE_7, '1);
  endtask

  task automatic test_random_mix(int n_req);
    repeat (n_req) send_random();
  endtask

  // sender holds off until the table has answered everything outstanding
  task automatic test_drain_pause();
    repeat (2) begin
      repeat (10) send_random();
      in_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (20) @(posedge clk);
    end
  endtask

  task automatic test_back_to_back(int n_req);
    no_idle = 1'b1;
    repeat (n_req) send_random();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_fill_and_full();
    test_random_mix(280);
    test_drain_pause();
    test_back_to_back(80);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb_sorted_list_table_top passed");
    else
      $display("tb_sorted_list_table_top failed");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb_sorted_list_table_top failed");
    $finish;
  end

endmodule
